FILE: rtl/aopb_pkg.sv
// aopb_pkg: pixel types, register indexes and the rounded 8-bit product
`timescale 1ns / 1ps
`default_nettype none

package aopb_pkg;

    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CEL_OPACITY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_OPACITY = 1'b1;

    localparam logic [7:0] OPACITY_RESET = 8'hFF;
    localparam logic [16:0] ROUND_BIAS   = 17'h00080;

    // divider layout: 16-bit dividend, four stages of four steps
    localparam int unsigned NUM_W      = 16;
    localparam int unsigned DIV_STAGES = 4;
    localparam int unsigned DIV_STEPS  = NUM_W / DIV_STAGES;
    localparam int unsigned NUM_CHAN   = 3;

    typedef struct packed {
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] src_alpha;
        logic [7:0] dst_red;
        logic [7:0] dst_green;
        logic [7:0] dst_blue;
        logic [7:0] dst_alpha;
    } t_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_out;

    // rounded a*b/255
    function automatic logic [7:0] mul8(input logic [7:0] a, input logic [7:0] b);
        logic [16:0] t;
        logic [17:0] u;
        t = ({9'd0, a} * {9'd0, b}) + ROUND_BIAS;
        u = {1'b0, t} + {9'd0, t[16:8]};
        return u[15:8];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/alpha_over_pixel_blend.sv
// alpha_over_pixel_blend: pipelined source-over blend of one rgba8 pixel pair
`timescale 1ns / 1ps
`default_nettype none

// Composites a source rgba8 pixel over the destination pixel below it with
// non-premultiplied source-over, the source alpha scaled by the rounded product
// of cel and layer opacity. One request enters per clock unless the output is
// stalled. Each request passes through the opacity, scaled alpha, result alpha
// and product stages, then the color divide (dst + (src - dst) * sa / ra), a
// 16-bit restoring divider laid out as four stages of four steps, and then the
// output register that holds the final add. A stall on the output holds the
// whole pipeline; nothing is dropped or repeated. Opacity registers may be
// written only while no request is in flight.
module alpha_over_pixel_blend
    import aopb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [7:0]           i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in                  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out                      o_out_data
);

    localparam int unsigned NSTG    = 4 + DIV_STAGES;
    localparam int unsigned DIV_LO  = 4;

    typedef struct packed {
        t_in                             pix;
        logic [7:0]                      opa;
        logic [7:0]                      sa;
        logic [7:0]                      ra;
        logic                            skip;
        logic [NUM_CHAN-1:0]             neg;
        logic [NUM_CHAN-1:0][7:0]        rem;
        logic [NUM_CHAN-1:0][NUM_W-1:0]  quo;
    } t_stage;

    logic [7:0]  r_cel_opa;
    logic [7:0]  r_layer_opa;

    t_stage      r_stg [NSTG];
    t_stage      n_stg [NSTG];
    logic [NSTG-1:0] r_vld;
    logic        r_out_vld;
    t_out        r_out;
    t_out        n_out;
    logic        advance;

    // only a full, stalled output register holds the pipe
    assign advance     = !(r_out_vld && i_out_stall);
    assign o_in_stall  = !advance;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cel_opa   <= OPACITY_RESET;
            r_layer_opa <= OPACITY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CEL_OPACITY:   r_cel_opa   <= i_cfg_data;
                CFG_LAYER_OPACITY: r_layer_opa <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: combined opacity
    always_comb begin
        n_stg[0]     = '0;
        n_stg[0].pix = i_in_data;
        n_stg[0].opa = mul8(r_cel_opa, r_layer_opa);
    end

    // stage 1: scaled source alpha
    always_comb begin
        n_stg[1]      = r_stg[0];
        n_stg[1].sa   = mul8(r_stg[0].pix.src_alpha, r_stg[0].opa);
        n_stg[1].skip = (r_stg[0].opa == 8'd0) || (r_stg[0].pix.src_alpha == 8'd0);
    end

    // stage 2: result alpha
    always_comb begin
        logic [7:0] m;
        logic [9:0] sum;
        n_stg[2] = r_stg[1];
        m        = mul8(r_stg[1].pix.dst_alpha, r_stg[1].sa);
        sum      = {2'd0, r_stg[1].pix.dst_alpha} + {2'd0, r_stg[1].sa} - {2'd0, m};
        n_stg[2].ra   = sum[7:0];
        n_stg[2].skip = r_stg[1].skip || (sum[7:0] == 8'd0);
    end

    // stage 3: |src - dst| * sa per channel, sign kept aside
    always_comb begin
        logic [NUM_CHAN-1:0][7:0] s;
        logic [NUM_CHAN-1:0][7:0] d;
        logic [7:0]               mag;
        s = {r_stg[2].pix.src_red, r_stg[2].pix.src_green, r_stg[2].pix.src_blue};
        d = {r_stg[2].pix.dst_red, r_stg[2].pix.dst_green, r_stg[2].pix.dst_blue};
        n_stg[3] = r_stg[2];
        for (int c = 0; c < NUM_CHAN; c++) begin
            n_stg[3].neg[c] = s[c] < d[c];
            mag = (s[c] < d[c]) ? (d[c] - s[c]) : (s[c] - d[c]);
            n_stg[3].quo[c] = {8'd0, mag} * {8'd0, r_stg[2].sa};
            n_stg[3].rem[c] = 8'd0;
        end
    end

    // restoring divide by ra, DIV_STEPS quotient bits per stage
    for (genvar k = DIV_LO; k < NSTG; k++) begin : g_div
        always_comb begin
            logic [8:0] part;
            n_stg[k] = r_stg[k-1];
            for (int c = 0; c < NUM_CHAN; c++) begin
                for (int j = 0; j < DIV_STEPS; j++) begin
                    part = {n_stg[k].rem[c], n_stg[k].quo[c][NUM_W-1]};
                    n_stg[k].quo[c] = {n_stg[k].quo[c][NUM_W-2:0], 1'b0};
                    if (part >= {1'b0, r_stg[k-1].ra}) begin
                        part = part - {1'b0, r_stg[k-1].ra};
                        n_stg[k].quo[c][0] = 1'b1;
                    end
                    n_stg[k].rem[c] = part[7:0];
                end
            end
        end
    end

    // final: dst +/- quotient, low 8 bits
    always_comb begin
        logic [NUM_CHAN-1:0][7:0] d;
        logic [NUM_CHAN-1:0][7:0] v;
        d = {r_stg[NSTG-1].pix.dst_red, r_stg[NSTG-1].pix.dst_green,
             r_stg[NSTG-1].pix.dst_blue};
        for (int c = 0; c < NUM_CHAN; c++) begin
            v[c] = r_stg[NSTG-1].neg[c] ? (d[c] - r_stg[NSTG-1].quo[c][7:0])
                                        : (d[c] + r_stg[NSTG-1].quo[c][7:0]);
        end
        if (r_stg[NSTG-1].skip) begin
            n_out.out_red   = r_stg[NSTG-1].pix.dst_red;
            n_out.out_green = r_stg[NSTG-1].pix.dst_green;
            n_out.out_blue  = r_stg[NSTG-1].pix.dst_blue;
            n_out.out_alpha = r_stg[NSTG-1].pix.dst_alpha;
        end else begin
            n_out.out_red   = v[2];
            n_out.out_green = v[1];
            n_out.out_blue  = v[0];
            n_out.out_alpha = r_stg[NSTG-1].ra;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_vld     <= {r_vld[NSTG-2:0], i_in_valid};
            r_out_vld <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int k = 0; k < NSTG; k++) begin
                r_stg[k] <= n_stg[k];
            end
            r_out <= n_out;
        end
    end

    // the pipe only holds when a result is waiting at the output
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_vld)
        else $error("input stalled with no result waiting");

    a_last_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_vld[NSTG-1]) |=> r_out_vld)
        else $error("request lost between last stage and output");

    // sa never exceeds ra, so the quotient fits in 8 bits
    a_quotient_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && !r_stg[NSTG-1].skip) |->
            (r_stg[NSTG-1].quo[0][NUM_W-1:8] == '0) &&
            (r_stg[NSTG-1].quo[1][NUM_W-1:8] == '0) &&
            (r_stg[NSTG-1].quo[2][NUM_W-1:8] == '0))
        else $error("blend quotient out of range");

    a_blend_alpha_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_vld[NSTG-1] && !r_stg[NSTG-1].skip) |=> (r_out.out_alpha != 8'd0))
        else $error("blended pixel with zero alpha");

    a_skip_passes_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_vld[NSTG-1] && r_stg[NSTG-1].skip) |=>
            (r_out.out_alpha == $past(r_stg[NSTG-1].pix.dst_alpha)) &&
            (r_out.out_red == $past(r_stg[NSTG-1].pix.dst_red)))
        else $error("skipped pixel did not pass destination");

endmodule

`default_nettype wire

FILE: bench/tb.sv
// tb: self-checking bench for the source-over rgba8 pixel blend
`timescale 1ns / 1ps

module tb;
    import aopb_pkg::*;

    localparam int unsigned RND_HALF    = 32'h80;
    localparam int          PIPE_LAT    = 9;
    localparam int          SETTLE      = PIPE_LAT + 6;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          RAND_PER_SET = 95;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = CFG_CEL_OPACITY;
    logic [7:0]           cfg_data  = 8'd0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in                  in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out                 out_data;

    // bench copy of the opacity registers
    logic [7:0] cel_op   = OPACITY_RESET;
    logic [7:0] layer_op = OPACITY_RESET;

    t_in  pending_px[$];
    t_out blend_expect[$];

    int   err_cnt       = 0;
    int   cycle_cnt     = 0;
    int   gap_left      = 0;
    int   stall_left    = 0;
    bit   src_gaps_on   = 1'b0;
    bit   sink_stalls_on = 1'b0;
    t_out want_px;

    alpha_over_pixel_blend uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #2 clk = ~clk;

    // rounded a*b/255
    function automatic logic [7:0] round_mul(input logic [7:0] a, input logic [7:0] b);
        int unsigned t;
        t = 32'(a) * 32'(b) + RND_HALF;
        return 8'(((t >> 8) + t) >> 8);
    endfunction

    function automatic logic [7:0] mix_chan(input logic [7:0] s, input logic [7:0] d,
                                            input logic [7:0] sa, input logic [7:0] ra);
        int diff;
        int q;
        diff = int'(s) - int'(d);
        q = (diff * int'(sa)) / int'(ra);
        return 8'(int'(d) + q);
    endfunction

    function automatic t_out blend_pixel(input t_in px);
        t_out       res;
        logic [7:0] opac;
        logic [7:0] sa;
        logic [7:0] ra;
        res = t_out'{px.dst_red, px.dst_green, px.dst_blue, px.dst_alpha};
        opac = round_mul(cel_op, layer_op);
        if (opac == 8'd0 || px.src_alpha == 8'd0)
            return res;
        sa = round_mul(px.src_alpha, opac);
        ra = px.dst_alpha + sa - round_mul(px.dst_alpha, sa);
        // transparent over transparent: nothing to divide by
        if (ra == 8'd0)
            return res;
        res.out_red   = mix_chan(px.src_red, px.dst_red, sa, ra);
        res.out_green = mix_chan(px.src_green, px.dst_green, sa, ra);
        res.out_blue  = mix_chan(px.src_blue, px.dst_blue, sa, ra);
        res.out_alpha = ra;
        return res;
    endfunction

    // mostly short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 8'd0;
        if (r < 3)
            return 8'hFF;
        if (r < 4)
            return 8'($urandom_range(1, 4));
        return 8'($urandom);
    endfunction

    function automatic t_in rand_pixel();
        t_in px;
        px = t_in'($urandom) << 32 | t_in'($urandom);
        px.src_alpha = rand_alpha();
        px.dst_alpha = rand_alpha();
        return px;
    endfunction

    // append a request to the sender's list
    task automatic queue_px(input t_in px);
        pending_px.insert(pending_px.size(), px);
    endtask

    task automatic check_chan(input string what, input logic [7:0] want,
                              input logic [7:0] got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CEL_OPACITY)
            cel_op = val;
        else
            layer_op = val;
    endtask

    task automatic set_opacity(input logic [7:0] cel, input logic [7:0] layer);
        write_reg(CFG_CEL_OPACITY, cel);
        write_reg(CFG_LAYER_OPACITY, layer);
        @(negedge clk);
    endtask

    // sender holds off until every request has drained through the pipe
    task automatic wait_idle();
        @(negedge clk);
        while (pending_px.size() != 0 || in_valid || blend_expect.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && !in_stall)
                blend_expect.insert(blend_expect.size(), blend_pixel(in_data));
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_px.size() != 0) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_px.pop_front();
                    gap_left = src_gaps_on ? pick_idle() : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output stall
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (blend_expect.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result with no request pending, expected none got %h",
                             $time, out_data);
                end else begin
                    want_px = blend_expect.pop_front();
                    check_chan("red", want_px.out_red, out_data.out_red);
                    check_chan("green", want_px.out_green, out_data.out_green);
                    check_chan("blue", want_px.out_blue, out_data.out_blue);
                    check_chan("alpha", want_px.out_alpha, out_data.out_alpha);
                end
            end
            if (sink_stalls_on && stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                stall_left = sink_stalls_on ? pick_idle() : 0;
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [7:0] op_cel[9];
        logic [7:0] op_layer[9];
        op_cel   = '{8'd0,   8'd255, 8'd1, 8'd255, 8'd128, 8'd255, 8'd0, 8'd0, 8'd0};
        op_layer = '{8'd255, 8'd0,   8'd1, 8'd1,   8'd200, 8'd255, 8'd0, 8'd0, 8'd0};
        for (int k = 6; k < 9; k++) begin
            op_cel[k]   = 8'($urandom);
            op_layer[k] = 8'($urandom);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed pixels at reset opacity
        queue_px(t_in'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        queue_px(t_in'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        queue_px(t_in'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
        queue_px(t_in'{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        queue_px(t_in'{8'h12, 8'h34, 8'h56, 8'h00, 8'h9A, 8'hBC, 8'hDE, 8'h77});
        queue_px(t_in'{8'hAA, 8'h55, 8'hAA, 8'h80, 8'h55, 8'hAA, 8'h55, 8'h80});
        queue_px(t_in'{8'h00, 8'hFF, 8'h80, 8'h01, 8'hFF, 8'h00, 8'h7F, 8'h00});
        queue_px(t_in'{8'hFF, 8'h00, 8'h7F, 8'h01, 8'h00, 8'hFF, 8'h80, 8'hFF});
        queue_px(t_in'{8'h10, 8'hF0, 8'h80, 8'h40, 8'hF0, 8'h10, 8'h81, 8'h01});
        queue_px(t_in'{8'h55, 8'hAA, 8'h55, 8'hFE, 8'hAA, 8'h55, 8'hAA, 8'h02});
        wait_idle();

        // opacity of one: weak source alpha over empty destination gives zero alpha
        set_opacity(8'd255, 8'd1);
        queue_px(t_in'{8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00});
        queue_px(t_in'{8'hFF, 8'h00, 8'h80, 8'h80, 8'h20, 8'h40, 8'h60, 8'h00});
        queue_px(t_in'{8'hFF, 8'h00, 8'h80, 8'hFF, 8'h20, 8'h40, 8'h60, 8'h00});
        queue_px(t_in'{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h10});
        queue_px(t_in'{8'hC3, 8'h3C, 8'h99, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        wait_idle();

        for (int k = 0; k < 9; k++) begin
            set_opacity(op_cel[k], op_layer[k]);
            src_gaps_on    = (k == 0) ? 1'b0 : ($urandom_range(0, 9) < 7);
            sink_stalls_on = (k == 0) ? 1'b0 : ($urandom_range(0, 9) < 7);
            for (int n = 0; n < RAND_PER_SET; n++)
                queue_px(rand_pixel());
            wait_idle();
        end

        if (err_cnt == 0 && blend_expect.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/aopb_pkg.sv
rtl/alpha_over_pixel_blend.sv
bench/tb.sv
